// File: rtl/core/far_pkg.sv
package far_pkg;

  // Operation codes
  localparam logic [2:0] OP_REDUCE = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;

  localparam int unsigned FUNC_BITS = 3;
  localparam int unsigned RES_NUM_BITS = 32;
  localparam int unsigned RES_DEN_BITS = 31;

endpackage

// File: rtl/core/fraction_arithmetic_reduce.sv
// Flow: the front end's product and combine registers, the queue, then in the back
// end one restoring remainder division per Euclid step (one bit per cycle, after a
// launch), then the two final divisions and the output register.
// Error and zero-numerator requests skip the gcd and divisions in the back end.
// Throughput: one item in the back end at a time; a two-entry queue lets the
// front end take further requests meanwhile. Reset: rst synchronous, clears valids.
module fraction_arithmetic_reduce
  import far_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_BITS-1:0] func,
  input  logic signed [OPERAND_BITS-1:0] first_num,
  input  logic [OPERAND_BITS-2:0] first_den,
  input  logic signed [OPERAND_BITS-1:0] second_num,
  input  logic [OPERAND_BITS-2:0] second_den,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [RES_NUM_BITS-1:0] result_num,
  output logic [RES_DEN_BITS-1:0] result_den,
  output logic                 div_by_zero
);

  localparam int unsigned W  = 2 * OPERAND_BITS + 1;
  localparam int unsigned QB = 2 * W + 3;

  logic         f_valid, f_ready, f_neg, f_err, f_zero;
  logic [W-1:0] f_mag, f_den;
  logic         b_valid, b_ready;
  logic [QB-1:0] b_data;

  far_front #(.OPERAND_BITS(OPERAND_BITS), .WIDE_BITS(W)) u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .first_num, .first_den,
    .second_num, .second_den,
    .q_valid(f_valid), .q_ready(f_ready), .q_neg(f_neg), .q_mag(f_mag),
    .q_den(f_den), .q_err(f_err), .q_zero(f_zero)
  );

  far_queue #(.DATA_BITS(QB)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_neg, f_err, f_zero, f_mag, f_den}),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  far_back #(.W(W)) u_back (
    .clk, .rst,
    .q_valid(b_valid), .q_ready(b_ready),
    .q_neg(b_data[QB-1]), .q_err(b_data[QB-2]), .q_zero(b_data[QB-3]),
    .q_mag(b_data[2*W-1:W]), .q_den(b_data[W-1:0]),
    .out_valid, .out_ready, .result_num, .result_den, .div_by_zero
  );

endmodule

// File: rtl/core/far_front.sv
// Front end: accept a request, form the products, classify errors
// and zero results, and push a sign-magnitude numerator with its denominator.
module far_front
  import far_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 16,
  parameter int unsigned WIDE_BITS = 2 * OPERAND_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [FUNC_BITS-1:0]        func,
  input  logic signed [OPERAND_BITS-1:0] first_num,
  input  logic [OPERAND_BITS-2:0]     first_den,
  input  logic signed [OPERAND_BITS-1:0] second_num,
  input  logic [OPERAND_BITS-2:0]     second_den,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic                        q_neg,
  output logic [WIDE_BITS-1:0]        q_mag,
  output logic [WIDE_BITS-1:0]        q_den,
  output logic                        q_err,
  output logic                        q_zero
);

  localparam int unsigned OB = OPERAND_BITS;
  localparam int unsigned PB = 2 * OPERAND_BITS;

  // Stage 1 registers: products
  logic              s1_valid;
  logic [2:0]        s1_op;
  logic              s1_err;
  logic signed [PB-1:0] p_a, p_b, p_d;
  logic signed [OB:0]   n1x, n2x, d1x, d2x;
  logic signed [PB-1:0] n1w, n2w, d1w, d2w;
  logic              uses_second;
  logic [2:0]        op;

  assign op = (func > OP_DIV) ? OP_REDUCE : func;
  assign uses_second = (op != OP_REDUCE);
  assign n1x = {first_num[OB-1], first_num};
  assign n2x = {second_num[OB-1], second_num};
  assign d1x = {2'b00, first_den};
  assign d2x = {2'b00, second_den};

  // Widen operands so each product keeps its full width
  assign n1w = PB'(n1x);
  assign n2w = PB'(n2x);
  assign d1w = PB'(d1x);
  assign d2w = PB'(d2x);

  logic s1_take;
  logic q_take;
  assign q_take   = !q_valid || q_ready;
  assign s1_take  = !s1_valid || q_take;
  assign in_ready = s1_take;

  // Capture products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
    end
    if (s1_take && in_valid) begin
      s1_op  <= op;
      s1_err <= (first_den == '0) || (uses_second && second_den == '0) ||
                (op == OP_DIV && second_num == '0);
      unique case (op)
        OP_MUL: begin
          p_a <= n1w * n2w;
          p_b <= '0;
          p_d <= d1w * d2w;
        end
        OP_DIV: begin
          p_a <= n1w * d2w;
          p_b <= '0;
          p_d <= d1w * n2w;
        end
        OP_ADD, OP_SUB: begin
          p_a <= n1w * d2w;
          p_b <= n2w * d1w;
          p_d <= d1w * d2w;
        end
        default: begin
          p_a <= n1w;
          p_b <= '0;
          p_d <= d1w;
        end
      endcase
    end
  end

  // Stage 2: combine, fix sign, take magnitudes
  logic signed [WIDE_BITS-1:0] sum, dd, rn, rd;
  always_comb begin
    dd = WIDE_BITS'(p_d);
    if (s1_op == OP_SUB) begin
      sum = WIDE_BITS'(p_a) - WIDE_BITS'(p_b);
    end else begin
      sum = WIDE_BITS'(p_a) + WIDE_BITS'(p_b);
    end
    if (dd < 0) begin
      rd = -dd;
      rn = -sum;
    end else begin
      rd = dd;
      rn = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_take) begin
      q_valid <= s1_valid;
    end
    if (q_take && s1_valid) begin
      q_err  <= s1_err;
      q_zero <= (rn == '0);
      q_neg  <= rn[WIDE_BITS-1];
      q_mag  <= rn[WIDE_BITS-1] ? WIDE_BITS'(-rn) : WIDE_BITS'(rn);
      q_den  <= rd;
    end
  end

endmodule

// File: rtl/core/far_queue.sv
// Two-entry queue between front and back.
module far_queue #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_data;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !do_rd) |=> cnt == 2'd2)
    else $error("queue lost entry");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && !do_wr) |=> !rd_valid)
    else $error("queue invented entry");

endmodule

// File: rtl/core/far_back.sv
// Back end: Euclid gcd by restoring remainder, then divide both terms by
// the gcd, one quotient bit per cycle through a shared subtractor.
module far_back
  import far_pkg::*;
#(
  parameter int unsigned W = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic                 q_neg,
  input  logic [W-1:0]         q_mag,
  input  logic [W-1:0]         q_den,
  input  logic                 q_err,
  input  logic                 q_zero,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [RES_NUM_BITS-1:0] result_num,
  output logic [RES_DEN_BITS-1:0] result_den,
  output logic                 div_by_zero
);

  localparam int unsigned CB = $clog2(W + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVN = 5'b00100,
    S_DIVD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [W-1:0]  un, ud, gx, gy;
  logic          neg;
  // Shared divider: dividend shifts into remainder, quotient collects bits
  logic [W-1:0]  dvd, dvs, quo, rem;
  logic [CB-1:0] cnt;
  logic [W:0]    trial;
  logic [W-1:0]  rem_sh;
  logic          div_busy;

  assign rem_sh = {rem[W-2:0], dvd[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};

  assign q_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid && q_ready) begin
        state_next = (q_err || q_zero) ? S_OUT : S_GCD;
      end
      S_GCD:  if (!div_busy && gy == '0) state_next = S_DIVN;
      S_DIVN: if (!div_busy && cnt == CB'(W)) state_next = S_DIVD;
      S_DIVD: if (!div_busy && cnt == CB'(W)) state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Run gcd steps and divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_busy  <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          neg <= q_neg;
          un  <= q_mag;
          ud  <= q_den;
          gx  <= q_mag;
          gy  <= q_den;
          div_busy <= 1'b0;
          cnt <= '0;
          if (q_err || q_zero) begin
            result_num  <= '0;
            result_den  <= RES_DEN_BITS'(1);
            div_by_zero <= q_err;
          end
        end
        S_GCD: begin
          if (!div_busy) begin
            if (gy != '0) begin
              dvd <= gx; dvs <= gy; rem <= '0; quo <= '0;
              cnt <= '0; div_busy <= 1'b1;
            end else begin
              dvd <= un; dvs <= gx; rem <= '0; quo <= '0;
              cnt <= '0; div_busy <= 1'b1;
            end
          end else begin
            dvd <= {dvd[W-2:0], 1'b0};
            rem <= trial[W] ? rem_sh : trial[W-1:0];
            cnt <= cnt + 1'b1;
            if (cnt == CB'(W - 1)) begin
              div_busy <= 1'b0;
              gx <= gy;
              gy <= trial[W] ? rem_sh : trial[W-1:0];
            end
          end
        end
        S_DIVN, S_DIVD: begin
          if (div_busy) begin
            dvd <= {dvd[W-2:0], 1'b0};
            rem <= trial[W] ? rem_sh : trial[W-1:0];
            quo <= {quo[W-2:0], !trial[W]};
            cnt <= cnt + 1'b1;
            if (cnt == CB'(W - 1)) div_busy <= 1'b0;
          end else if (cnt == CB'(W)) begin
            if (state == S_DIVN) begin
              result_num <= neg ? RES_NUM_BITS'(-quo) : RES_NUM_BITS'(quo);
              dvd <= ud; rem <= '0; quo <= '0; cnt <= '0; div_busy <= 1'b1;
            end else begin
              result_den  <= RES_DEN_BITS'(quo);
              div_by_zero <= 1'b0;
            end
          end
        end
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == S_IDLE)
    else $error("accepted while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && div_by_zero) |-> (result_num == '0 && result_den == 1))
    else $error("error result not 0/1");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_den != '0)
    else $error("zero denominator out");

endmodule

// File: sim/fraction_arithmetic_reduce_test.sv
`timescale 1ns / 1ps

module fraction_arithmetic_reduce_test;
  import far_pkg::*;

  localparam int unsigned OPERAND_BITS = 16;
  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 1300;

  typedef struct packed {
    logic signed [RES_NUM_BITS-1:0] num;
    logic [RES_DEN_BITS-1:0] den;
    logic err;
  } fraction_t;

  typedef struct {
    logic [FUNC_BITS-1:0] op;
    logic signed [OPERAND_BITS-1:0] n1;
    logic [OPERAND_BITS-2:0] d1;
    logic signed [OPERAND_BITS-1:0] n2;
    logic [OPERAND_BITS-2:0] d2;
    bit known;
    fraction_t res;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_BITS-1:0] func = OP_REDUCE;
  logic signed [OPERAND_BITS-1:0] first_num = '0;
  logic [OPERAND_BITS-2:0] first_den = (OPERAND_BITS-1)'(1);
  logic signed [OPERAND_BITS-1:0] second_num = '0;
  logic [OPERAND_BITS-2:0] second_den = (OPERAND_BITS-1)'(1);
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RES_NUM_BITS-1:0] result_num;
  logic [RES_DEN_BITS-1:0] result_den;
  logic div_by_zero;

  fraction_t pending_fractions[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;

  fraction_arithmetic_reduce #(.OPERAND_BITS(OPERAND_BITS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .first_num(first_num), .first_den(first_den),
    .second_num(second_num), .second_den(second_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_num(result_num), .result_den(result_den), .div_by_zero(div_by_zero)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Compute the reduced fraction at full width
  function automatic fraction_t reduce_fraction(request_t rq);
    longint n1, d1, n2, d2, rn, rd;
    longint unsigned un, ud, g;
    fraction_t f;
    n1 = rq.n1;
    n2 = rq.n2;
    d1 = rq.d1;
    d2 = rq.d2;
    f = '{num: '0, den: RES_DEN_BITS'(1), err: 1'b1};
    if (d1 == 0 || (rq.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV} && d2 == 0) ||
        (rq.op == OP_DIV && n2 == 0))
      return f;
    case (rq.op)
      OP_ADD: begin rn = n1 * d2 + n2 * d1; rd = d1 * d2; end
      OP_SUB: begin rn = n1 * d2 - n2 * d1; rd = d1 * d2; end
      OP_MUL: begin rn = n1 * n2; rd = d1 * d2; end
      OP_DIV: begin rn = n1 * d2; rd = d1 * n2; end
      default: begin rn = n1; rd = d1; end
    endcase
    f.err = 1'b0;
    if (rd < 0) begin
      rd = -rd;
      rn = -rn;
    end
    if (rn == 0) return f;
    un = (rn < 0) ? -rn : rn;
    ud = rd;
    g = gcd64(un, ud);
    un = un / g;
    ud = ud / g;
    f.num = RES_NUM_BITS'((rn < 0) ? -un : un);
    f.den = RES_DEN_BITS'(ud);
    return f;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(request_t rq);
    func <= rq.op;
    first_num <= rq.n1;
    first_den <= rq.d1;
    second_num <= rq.n2;
    second_den <= rq.d2;
    in_valid <= 1'b1;
    pending_fractions.push_back(rq.known ? rq.res : reduce_fraction(rq));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic request_t make_request(logic [2:0] op, int n1, int d1, int n2, int d2);
    request_t rq;
    rq.op = op;
    rq.n1 = OPERAND_BITS'(n1);
    rq.d1 = (OPERAND_BITS-1)'(d1);
    rq.n2 = OPERAND_BITS'(n2);
    rq.d2 = (OPERAND_BITS-1)'(d2);
    rq.known = 1'b0;
    rq.res = '0;
    return rq;
  endfunction

  function automatic request_t make_known(logic [2:0] op, int n1, int d1, int n2, int d2,
                                          int rn, int rd, bit err);
    request_t rq;
    rq = make_request(op, n1, d1, n2, d2);
    rq.known = 1'b1;
    rq.res = '{num: RES_NUM_BITS'(rn), den: RES_DEN_BITS'(rd), err: err};
    return rq;
  endfunction

  function automatic int rand_num();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return -32768;
      2: return 32767;
      3: return $urandom_range(0, 40) - 20;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic int rand_den();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(1, 24);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // Stimulus: directed table, then random bursts
  initial begin
    request_t directed[$];
    int burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed = '{
      make_known(OP_REDUCE, 0, 5, 0, 0, 0, 1, 0),
      make_known(OP_REDUCE, 6, 4, 0, 0, 3, 2, 0),
      make_known(OP_REDUCE, -6, 4, 9, 0, -3, 2, 0),
      make_known(OP_REDUCE, 7, 0, 1, 1, 0, 1, 1),
      make_known(OP_ADD, 1, 1, 1, 0, 0, 1, 1),
      make_known(OP_DIV, 1, 2, 0, 3, 0, 1, 1),
      make_known(OP_MUL, 0, 3, 5, 7, 0, 1, 0),
      make_known(3'd5, 10, 4, 1, 1, 5, 2, 0),
      make_known(3'd6, -32768, 1, 0, 0, -32768, 1, 0),
      make_known(3'd7, 32767, 32767, 0, 0, 1, 1, 0),
      make_request(OP_ADD, 32767, 32767, 32767, 1),
      make_request(OP_ADD, -32768, 1, -32768, 1),
      make_request(OP_SUB, -32768, 32767, 32767, 32766),
      make_request(OP_SUB, 3, 4, 3, 4),
      make_request(OP_MUL, -32768, 1, -32768, 1),
      make_request(OP_MUL, 32767, 32766, -32768, 32767),
      make_request(OP_DIV, -32768, 32767, -1, 32767),
      make_request(OP_DIV, 5, 7, -3, 11),
      make_request(OP_DIV, 32767, 1, -32768, 32767),
      make_request(OP_ADD, 1, 3, -1, 3)
    };
    foreach (directed[i]) send_request(directed[i]);
    in_valid <= 1'b0;
    // Hold off until every outstanding result is back
    while (pending_fractions.size() != 0) @(negedge clk);
    for (int i = 0; i < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && i < RANDOM_ITEMS; b++, i++)
        send_request(make_request(FUNC_BITS'($urandom_range(0, 7)), rand_num(), rand_den(),
                                  rand_num(), rand_den()));
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern: random stretches of open, mostly open, mostly stalled and stalled
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 300)) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    fraction_t exp_f;
    if (!rst && out_valid && out_ready) begin
      if (pending_fractions.size() == 0) begin
        $error("unexpected result num=%0d den=%0d err=%0b", result_num, result_den,
               div_by_zero);
        errors++;
      end else begin
        exp_f = pending_fractions.pop_front();
        if (result_num !== exp_f.num) begin
          $error("result_num expected %0d actual %0d", exp_f.num, result_num);
          errors++;
        end
        if (result_den !== exp_f.den) begin
          $error("result_den expected %0d actual %0d", exp_f.den, result_den);
          errors++;
        end
        if (div_by_zero !== exp_f.err) begin
          $error("div_by_zero expected %0b actual %0b", exp_f.err, div_by_zero);
          errors++;
        end
      end
    end
  end

  // Watchdog and end of run
  initial begin
    bit timed_out;
    timed_out = 1'b0;
    while (!(stim_done && pending_fractions.size() == 0) && !timed_out) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (!timed_out && errors == 0 && pending_fractions.size() == 0)
      $display("[fraction_arithmetic_reduce] OK");
    else
      $display("[fraction_arithmetic_reduce] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/far_pkg.sv
rtl/core/far_front.sv
rtl/core/far_queue.sv
rtl/core/far_back.sv
rtl/core/fraction_arithmetic_reduce.sv
sim/fraction_arithmetic_reduce_test.sv
